>>> rtl/vpsb_pkg.sv
// Shared types, constants and fixed-point helpers for the Verlet particle step.
package vpsb_pkg;

    // Number of register stages from input transfer to output register
    localparam int unsigned NUM_STAGES = 9;

    // Fixed shifts of the dt^2 and restitution products
    localparam int unsigned DT_SHIFT   = 32;
    localparam int unsigned REST_SHIFT = 15;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DT_SQUARED   = 3'd0,
        CFG_INV_DT       = 3'd1,
        CFG_BOUND_LEFT   = 3'd2,
        CFG_BOUND_RIGHT  = 3'd3,
        CFG_BOUND_TOP    = 3'd4,
        CFG_BOUND_BOTTOM = 3'd5,
        CFG_BOUNDS_ON    = 3'd6,
        CFG_RESTITUTION  = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [31:0]        RST_DT_SQUARED   = 32'd18;
    localparam logic [30:0]        RST_INV_DT       = 31'd3932160;
    localparam logic signed [31:0] RST_BOUND_LEFT   = 32'sd0;
    localparam logic signed [31:0] RST_BOUND_RIGHT  = 32'sd52428800;
    localparam logic signed [31:0] RST_BOUND_TOP    = 32'sd0;
    localparam logic signed [31:0] RST_BOUND_BOTTOM = 32'sd39321600;
    localparam logic               RST_BOUNDS_ON    = 1'b1;
    localparam logic [15:0]        RST_RESTITUTION  = 16'd26214;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic [30:0]        inv_mass;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_prev_x;
        logic signed [31:0] new_prev_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
    } t_out_item;

    // Sign-extend a 32-bit value to 64 bits
    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // Saturate a 64-bit signed value to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if ((&x[63:31]) || !(|x[63:31])) begin
            res = x[31:0];
        end else if (x[63]) begin
            res = S32_MIN;
        end else begin
            res = S32_MAX;
        end
        return res;
    endfunction

endpackage

>>> rtl/vpsb_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface vpsb_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/verlet_particle_step_with_bounds.sv
// Top level of the 2D position-Verlet particle step with boundary clamping.
//
// Takes one particle per cycle while the output accepts and returns its new
// position, previous position and velocity in Q16.16 with saturation. The
// nine-stage pipeline is built around four multipliers per axis (force by
// inverse mass, acceleration by dt^2, displacement by inverse dt, velocity
// by restitution). Each stage holds while the stage after it is full and
// stalled, so the input keeps accepting while bubbles remain. The user must
// write configuration registers through the plain write port only while no
// item is in flight; the block itself does not enforce this.
module verlet_particle_step_with_bounds #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    vpsb_stream_if.sink                        i_in,
    vpsb_stream_if.source                      o_out,
    input  logic                               i_cfg_we,
    input  logic [vpsb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vpsb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned NSTG = vpsb_pkg::NUM_STAGES;

    logic [31:0]        r_dt_squared;
    logic [30:0]        r_inv_dt;
    logic signed [31:0] r_bound_left, r_bound_right, r_bound_top, r_bound_bottom;
    logic               r_bounds_on;
    logic [15:0]        r_restitution;

    logic [NSTG-1:0]    r_vld;
    logic [NSTG:0]      w_rdy;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt_squared   <= vpsb_pkg::RST_DT_SQUARED;
            r_inv_dt       <= vpsb_pkg::RST_INV_DT;
            r_bound_left   <= vpsb_pkg::RST_BOUND_LEFT;
            r_bound_right  <= vpsb_pkg::RST_BOUND_RIGHT;
            r_bound_top    <= vpsb_pkg::RST_BOUND_TOP;
            r_bound_bottom <= vpsb_pkg::RST_BOUND_BOTTOM;
            r_bounds_on    <= vpsb_pkg::RST_BOUNDS_ON;
            r_restitution  <= vpsb_pkg::RST_RESTITUTION;
        end else if (i_cfg_we) begin
            case (vpsb_pkg::t_cfg_idx'(i_cfg_idx))
                vpsb_pkg::CFG_DT_SQUARED:   r_dt_squared   <= i_cfg_data;
                vpsb_pkg::CFG_INV_DT:       r_inv_dt       <= i_cfg_data[30:0];
                vpsb_pkg::CFG_BOUND_LEFT:   r_bound_left   <= i_cfg_data;
                vpsb_pkg::CFG_BOUND_RIGHT:  r_bound_right  <= i_cfg_data;
                vpsb_pkg::CFG_BOUND_TOP:    r_bound_top    <= i_cfg_data;
                vpsb_pkg::CFG_BOUND_BOTTOM: r_bound_bottom <= i_cfg_data;
                vpsb_pkg::CFG_BOUNDS_ON:    r_bounds_on    <= i_cfg_data[0];
                vpsb_pkg::CFG_RESTITUTION:  r_restitution  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Stage may load when it is empty or its contents move on
    always_comb begin
        w_rdy[NSTG] = o_out.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready  = w_rdy[0];
    assign o_out.valid = r_vld[NSTG-1];

    vpsb_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .i_clk         (i_clk),
        .i_en          (w_rdy[NSTG-1:0]),
        .i_pos         (i_in.data.pos_x),
        .i_prev        (i_in.data.prev_x),
        .i_force       (i_in.data.force_x),
        .i_accel       (i_in.data.accel_x),
        .i_vel         (i_in.data.vel_x),
        .i_inv_mass    (i_in.data.inv_mass),
        .i_dt_squared  (r_dt_squared),
        .i_inv_dt      (r_inv_dt),
        .i_bound_lo    (r_bound_left),
        .i_bound_hi    (r_bound_right),
        .i_bounds_on   (r_bounds_on),
        .i_restitution (r_restitution),
        .o_new_pos     (o_out.data.new_pos_x),
        .o_new_prev    (o_out.data.new_prev_x),
        .o_new_vel     (o_out.data.new_vel_x)
    );

    vpsb_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .i_clk         (i_clk),
        .i_en          (w_rdy[NSTG-1:0]),
        .i_pos         (i_in.data.pos_y),
        .i_prev        (i_in.data.prev_y),
        .i_force       (i_in.data.force_y),
        .i_accel       (i_in.data.accel_y),
        .i_vel         (i_in.data.vel_y),
        .i_inv_mass    (i_in.data.inv_mass),
        .i_dt_squared  (r_dt_squared),
        .i_inv_dt      (r_inv_dt),
        .i_bound_lo    (r_bound_top),
        .i_bound_hi    (r_bound_bottom),
        .i_bounds_on   (r_bounds_on),
        .i_restitution (r_restitution),
        .o_new_pos     (o_out.data.new_pos_y),
        .o_new_prev    (o_out.data.new_prev_y),
        .o_new_vel     (o_out.data.new_vel_y)
    );

endmodule

>>> rtl/vpsb_axis.sv
// One coordinate axis of the Verlet step: integration, velocity, clamp and bounce.
module vpsb_axis #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic [vpsb_pkg::NUM_STAGES-1:0]      i_en,
    // item fields for this axis
    input  logic signed [31:0]                   i_pos,
    input  logic signed [31:0]                   i_prev,
    input  logic signed [31:0]                   i_force,
    input  logic signed [31:0]                   i_accel,
    input  logic signed [31:0]                   i_vel,
    input  logic [30:0]                          i_inv_mass,
    // configuration
    input  logic [31:0]                          i_dt_squared,
    input  logic [30:0]                          i_inv_dt,
    input  logic signed [31:0]                   i_bound_lo,
    input  logic signed [31:0]                   i_bound_hi,
    input  logic                                 i_bounds_on,
    input  logic [15:0]                          i_restitution,
    // results
    output logic signed [31:0]                   o_new_pos,
    output logic signed [31:0]                   o_new_prev,
    output logic signed [31:0]                   o_new_vel
);

    // Stage 0: force times inverse mass
    logic signed [63:0] r0_prod;
    logic signed [31:0] r0_acc, r0_cur, r0_prv, r0_vel;
    logic               r0_stat;
    // Stage 1: acceleration
    logic signed [31:0] r1_a, r1_cur, r1_prv, r1_vel;
    logic               r1_stat;
    // Stage 2: acceleration times dt^2
    logic signed [63:0] r2_prod;
    logic signed [31:0] r2_cur, r2_prv, r2_vel;
    logic               r2_stat;
    // Stage 3: new position
    logic signed [31:0] r3_np, r3_pp, r3_cur, r3_vel;
    logic               r3_stat;
    // Stage 4: displacement and bound check
    logic signed [32:0] r4_d;
    logic signed [31:0] r4_pos, r4_pp, r4_vel;
    logic               r4_stat, r4_hit;
    // Stage 5: displacement times inverse dt
    logic signed [63:0] r5_prod;
    logic signed [31:0] r5_pos, r5_pp, r5_vel;
    logic               r5_stat, r5_hit;
    // Stage 6: velocity
    logic signed [31:0] r6_nv, r6_pos, r6_pp;
    logic               r6_hit;
    // Stage 7: reflected velocity product
    logic signed [63:0] r7_prod;
    logic signed [31:0] r7_nv, r7_pos, r7_pp;
    logic               r7_hit;
    // Stage 8: output register
    logic signed [31:0] r8_pos, r8_pp, r8_nv;

    logic signed [63:0] n1_sum, n3_sum, n4_diff;
    logic signed [31:0] n3_np, n4_pos;
    logic               n4_lo, n4_hi;
    logic signed [32:0] n7_neg;

    // Combinational sums, bound checks and negation between the stages
    always_comb begin
        n1_sum  = vpsb_pkg::sx64(vpsb_pkg::sat32(r0_prod >>> FRAC_BITS))
                + vpsb_pkg::sx64(r0_acc);
        n3_sum  = (vpsb_pkg::sx64(r2_cur) <<< 1) - vpsb_pkg::sx64(r2_prv)
                + (r2_prod >>> vpsb_pkg::DT_SHIFT);
        n3_np   = r2_stat ? r2_cur : vpsb_pkg::sat32(n3_sum);
        n4_diff = vpsb_pkg::sx64(r3_np) - vpsb_pkg::sx64(r3_cur);
        n4_lo   = i_bounds_on && (r3_np < i_bound_lo);
        n4_hi   = i_bounds_on && !(r3_np < i_bound_lo) && (r3_np > i_bound_hi);
        n4_pos  = n4_lo ? i_bound_lo : (n4_hi ? i_bound_hi : r3_np);
        n7_neg  = -{r6_nv[31], r6_nv};
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_prod <= i_force * $signed({1'b0, i_inv_mass});
            r0_acc  <= i_accel;
            r0_cur  <= i_pos;
            r0_prv  <= i_prev;
            r0_vel  <= i_vel;
            r0_stat <= (i_inv_mass == '0);
        end
        if (i_en[1]) begin
            r1_a    <= vpsb_pkg::sat32(n1_sum);
            r1_cur  <= r0_cur;
            r1_prv  <= r0_prv;
            r1_vel  <= r0_vel;
            r1_stat <= r0_stat;
        end
        if (i_en[2]) begin
            r2_prod <= r1_a * $signed({1'b0, i_dt_squared});
            r2_cur  <= r1_cur;
            r2_prv  <= r1_prv;
            r2_vel  <= r1_vel;
            r2_stat <= r1_stat;
        end
        if (i_en[3]) begin
            r3_np   <= n3_np;
            r3_pp   <= r2_stat ? r2_prv : r2_cur;
            r3_cur  <= r2_cur;
            r3_vel  <= r2_vel;
            r3_stat <= r2_stat;
        end
        if (i_en[4]) begin
            r4_d    <= n4_diff[32:0];
            r4_pos  <= n4_pos;
            r4_pp   <= r3_pp;
            r4_vel  <= r3_vel;
            r4_stat <= r3_stat;
            r4_hit  <= n4_lo || n4_hi;
        end
        if (i_en[5]) begin
            r5_prod <= r4_d * $signed({1'b0, i_inv_dt});
            r5_pos  <= r4_pos;
            r5_pp   <= r4_pp;
            r5_vel  <= r4_vel;
            r5_stat <= r4_stat;
            r5_hit  <= r4_hit;
        end
        if (i_en[6]) begin
            r6_nv  <= r5_stat ? r5_vel : vpsb_pkg::sat32(r5_prod >>> FRAC_BITS);
            r6_pos <= r5_pos;
            r6_pp  <= r5_pp;
            r6_hit <= r5_hit;
        end
        if (i_en[7]) begin
            r7_prod <= n7_neg * $signed({1'b0, i_restitution});
            r7_nv   <= r6_nv;
            r7_pos  <= r6_pos;
            r7_pp   <= r6_pp;
            r7_hit  <= r6_hit;
        end
        if (i_en[8]) begin
            r8_nv  <= r7_hit ? vpsb_pkg::sat32(r7_prod >>> vpsb_pkg::REST_SHIFT) : r7_nv;
            r8_pos <= r7_pos;
            r8_pp  <= r7_pp;
        end
    end

    assign o_new_pos  = r8_pos;
    assign o_new_prev = r8_pp;
    assign o_new_vel  = r8_nv;

endmodule
